>>> src/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, muted while reset is asserted.
`define MHRGB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check that also holds through reset.
`define MHRGB_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/mhrgb_pkg.sv
package mhrgb_pkg;

    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int SAMPLE_WIDTH_DEF      = 16;
    localparam int ATAN_LEN              = 24;
    localparam int ZW                    = 32;   // angle accumulator, 28 fraction bits

    typedef logic signed [ZW-1:0] angle_t;
    typedef logic [30:0]          uangle_t;      // folded angle, 0 .. 2*pi
    typedef logic [15:0]          rad_t;
    typedef logic [14:0]          deg_t;
    typedef logic [7:0]           level_t;

    localparam angle_t     ANG_PI      = 32'sd843314857;
    localparam angle_t     ANG_TWO_PI  = 32'sd1686629713;
    localparam logic [31:0] DEG64_SCALE = 32'd3845054675;   // 11520/pi in Q.20
    localparam deg_t       DEG64_MAX   = 15'd23039;
    localparam deg_t       SEG_UNITS   = 15'd7680;          // 120 degrees in 1/64 units

    // atan(2^-i) in units of 2^-28 rad
    function automatic angle_t atan_entry(input int unsigned idx);
        angle_t v;
        unique case (idx)
            0:  v = 32'sd210828714;
            1:  v = 32'sd124459457;
            2:  v = 32'sd65760959;
            3:  v = 32'sd33381290;
            4:  v = 32'sd16755422;
            5:  v = 32'sd8385879;
            6:  v = 32'sd4193963;
            7:  v = 32'sd2097109;
            8:  v = 32'sd1048571;
            9:  v = 32'sd524287;
            10: v = 32'sd262144;
            11: v = 32'sd131072;
            12: v = 32'sd65536;
            13: v = 32'sd32768;
            14: v = 32'sd16384;
            15: v = 32'sd8192;
            16: v = 32'sd4096;
            17: v = 32'sd2048;
            18: v = 32'sd1024;
            19: v = 32'sd512;
            20: v = 32'sd256;
            21: v = 32'sd128;
            22: v = 32'sd64;
            23: v = 32'sd32;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> src/mhrgb_cordic_cell.sv
module mhrgb_cordic_cell
    import mhrgb_pkg::*;
#(
    parameter int XW  = SAMPLE_WIDTH_DEF + 3,
    parameter int IDX = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [XW-1:0] in_x,
    input  logic signed [XW-1:0] in_y,
    input  angle_t               in_z,
    input  logic                 in_zero,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [XW-1:0] out_x,
    output logic signed [XW-1:0] out_y,
    output angle_t               out_z,
    output logic                 out_zero
);

    localparam angle_t ATAN_I = atan_entry(IDX);

    logic                 valid_reg;
    logic signed [XW-1:0] x_reg, x_next;
    logic signed [XW-1:0] y_reg, y_next;
    angle_t               z_reg, z_next;
    logic                 zero_reg;
    logic signed [XW-1:0] xs, ys;
    logic                 y_pos;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        xs    = in_x >>> IDX;
        ys    = in_y >>> IDX;
        y_pos = !in_y[XW-1] && (in_y != '0);
        if (y_pos) begin
            x_next = in_x + ys;
            y_next = in_y - xs;
            z_next = in_z + ATAN_I;
        end else begin
            x_next = in_x - ys;
            y_next = in_y + xs;
            z_next = in_z - ATAN_I;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            zero_reg <= in_zero;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_zero  = zero_reg;

endmodule

>>> src/mhrgb_post.sv
module mhrgb_post
    import mhrgb_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  angle_t in_z,
    input  logic   in_zero,
    output logic   out_valid,
    input  logic   out_ready,
    output rad_t   out_rad,
    output deg_t   out_deg
);

    // stage A: fold into 0 .. 2*pi
    logic    fold_valid_reg;
    uangle_t fold_reg, fold_next;
    logic    fold_ready;
    angle_t  z_eff;

    // stage B: scale to 1/64 degree
    logic        scale_valid_reg;
    rad_t        rad_reg;
    deg_t        deg_reg;
    logic [62:0] prod;

    assign fold_ready = !scale_valid_reg || out_ready;
    assign in_ready   = !fold_valid_reg || fold_ready;

    always_comb begin
        z_eff = in_zero ? '0 : in_z;
        if (z_eff[ZW-1]) begin
            fold_next = uangle_t'(z_eff + ANG_TWO_PI);
        end else if (z_eff >= ANG_TWO_PI) begin
            fold_next = uangle_t'(z_eff - ANG_TWO_PI);
        end else begin
            fold_next = uangle_t'(z_eff);
        end
    end

    assign prod = 63'(fold_reg) * 63'(DEG64_SCALE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_valid_reg  <= 1'b0;
            scale_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                fold_valid_reg <= in_valid;
            end
            if (fold_ready) begin
                scale_valid_reg <= fold_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            fold_reg <= fold_next;
        end
        if (fold_ready && fold_valid_reg) begin
            rad_reg <= fold_reg[30:15];
            deg_reg <= prod[62:48];
        end
    end

    assign out_valid = scale_valid_reg;
    assign out_rad   = rad_reg;
    assign out_deg   = deg_reg;

endmodule

>>> src/mhrgb_color.sv
module mhrgb_color
    import mhrgb_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  rad_t   in_rad,
    input  deg_t   in_deg,
    output logic   out_valid,
    input  logic   out_ready,
    output rad_t   out_rad,
    output deg_t   out_deg,
    output level_t out_red,
    output level_t out_green,
    output level_t out_blue
);

    typedef enum logic [1:0] {
        SEG_RED_GREEN  = 2'd0,
        SEG_GREEN_BLUE = 2'd1,
        SEG_BLUE_RED   = 2'd2
    } seg_t;

    logic        valid_reg;
    rad_t        rad_reg;
    deg_t        deg_reg, deg_next;
    level_t      red_reg, red_next;
    level_t      green_reg, green_next;
    level_t      blue_reg, blue_next;
    seg_t        seg;
    logic [12:0] frac;
    logic [12:0] rest;
    logic [16:0] up17, down17;
    level_t      up, down;

    assign in_ready = !valid_reg || out_ready;

    // 255/7680 reduces to 17/512: scale by 17, drop nine bits
    always_comb begin
        deg_next = (in_deg > DEG64_MAX) ? DEG64_MAX : in_deg;
        if (deg_next >= 15'(2 * SEG_UNITS)) begin
            seg  = SEG_BLUE_RED;
            frac = 13'(deg_next - 15'(2 * SEG_UNITS));
        end else if (deg_next >= SEG_UNITS) begin
            seg  = SEG_GREEN_BLUE;
            frac = 13'(deg_next - SEG_UNITS);
        end else begin
            seg  = SEG_RED_GREEN;
            frac = 13'(deg_next);
        end
        rest   = 13'(SEG_UNITS) - frac;
        up17   = {frac, 4'b0000} + 17'(frac);
        down17 = {rest, 4'b0000} + 17'(rest);
        up     = up17[16:9];
        down   = down17[16:9];
        unique case (seg)
            SEG_RED_GREEN: begin
                red_next = down; green_next = up;   blue_next = '0;
            end
            SEG_GREEN_BLUE: begin
                red_next = '0;   green_next = down; blue_next = up;
            end
            SEG_BLUE_RED: begin
                red_next = up;   green_next = '0;   blue_next = down;
            end
            default: begin
                red_next = '0;   green_next = '0;   blue_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            rad_reg   <= in_rad;
            deg_reg   <= deg_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_deg   = deg_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;

endmodule

>>> src/magnetometer_heading_to_rgb_top.sv
// Channel   Ports                                  Beat carries
// -------   -------------------------------------  -----------------------------------
// s_        s_valid s_ready s_mag_x s_mag_y         one magnetometer sample (x, y)
// m_        m_valid m_ready m_heading_radians      heading in Q3.13 rad and 1/64 deg,
//           m_heading_degrees m_red/green/blue_*   plus the hue-wheel color
//
// One beat in and one beat out per cycle, sustained while m_ready stays high.
// Registered stages in order: pre-rotation, one cell per iteration, fold,
// degree multiply, color.
// Every stage has its own valid bit and takes a new beat whenever it is empty or its
// successor moves, so bubbles close up while m_ready is low.
// Reset (aresetn low at a clock edge) clears only the valid bits.
module magnetometer_heading_to_rgb_top
    import mhrgb_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF,
    parameter int SAMPLE_WIDTH      = SAMPLE_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_mag_x,
    input  logic signed [SAMPLE_WIDTH-1:0] s_mag_y,
    output logic                           m_valid,
    input  logic                           m_ready,
    output rad_t                           m_heading_radians,
    output deg_t                           m_heading_degrees,
    output level_t                         m_red_level,
    output level_t                         m_green_level,
    output level_t                         m_blue_level
);

    // the table stops at 24 entries; run no more iterations than that
    localparam int NUM_ITER = (CORDIC_ITERATIONS < ATAN_LEN) ? CORDIC_ITERATIONS : ATAN_LEN;
    // room for the negated minimum plus the CORDIC gain and the y swing
    localparam int XW = SAMPLE_WIDTH + 3;

    // pre-rotation stage
    logic                 pre_valid_reg;
    logic signed [XW-1:0] pre_x_reg, pre_x_next;
    logic signed [XW-1:0] pre_y_reg, pre_y_next;
    angle_t               pre_z_reg, pre_z_next;
    logic                 pre_zero_reg, pre_zero_next;
    logic signed [XW-1:0] ext_x, ext_y;

    // chain of CORDIC cells; index i is the input of cell i
    logic                 ch_valid [0:NUM_ITER];
    logic                 ch_ready [0:NUM_ITER];
    logic signed [XW-1:0] ch_x     [0:NUM_ITER];
    logic signed [XW-1:0] ch_y     [0:NUM_ITER];
    angle_t               ch_z     [0:NUM_ITER];
    logic                 ch_zero  [0:NUM_ITER];

    // post stages to color stage
    logic post_valid, post_ready;
    rad_t post_rad;
    deg_t post_deg;

    // Sign-extend, then turn a sample with negative x by pi so the
    // vectoring loop starts in the right half plane.
    always_comb begin
        ext_x         = signed'({{3{s_mag_x[SAMPLE_WIDTH-1]}}, s_mag_x});
        ext_y         = signed'({{3{s_mag_y[SAMPLE_WIDTH-1]}}, s_mag_y});
        pre_zero_next = (s_mag_x == '0) && (s_mag_y == '0);
        if (ext_x[XW-1]) begin
            pre_x_next = -ext_x;
            pre_y_next = -ext_y;
            pre_z_next = ANG_PI;
        end else begin
            pre_x_next = ext_x;
            pre_y_next = ext_y;
            pre_z_next = '0;
        end
    end

    // take a beat whenever the stage is empty or the first cell moves
    assign s_ready = !pre_valid_reg || ch_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pre_valid_reg <= 1'b0;
        end else if (s_ready) begin
            pre_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            pre_x_reg    <= pre_x_next;
            pre_y_reg    <= pre_y_next;
            pre_z_reg    <= pre_z_next;
            pre_zero_reg <= pre_zero_next;
        end
    end

    assign ch_valid[0] = pre_valid_reg;
    assign ch_x[0]     = pre_x_reg;
    assign ch_y[0]     = pre_y_reg;
    assign ch_z[0]     = pre_z_reg;
    assign ch_zero[0]  = pre_zero_reg;

    // one cell per iteration, each with its own shift and arctangent constant
    for (genvar i = 0; i < NUM_ITER; i++) begin : g_cell
        mhrgb_cordic_cell #(
            .XW  (XW),
            .IDX (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (ch_valid[i]),
            .in_ready  (ch_ready[i]),
            .in_x      (ch_x[i]),
            .in_y      (ch_y[i]),
            .in_z      (ch_z[i]),
            .in_zero   (ch_zero[i]),
            .out_valid (ch_valid[i+1]),
            .out_ready (ch_ready[i+1]),
            .out_x     (ch_x[i+1]),
            .out_y     (ch_y[i+1]),
            .out_z     (ch_z[i+1]),
            .out_zero  (ch_zero[i+1])
        );
    end

    // Fold the angle and scale it to degrees; x and y of the last cell drop here.
    mhrgb_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ch_valid[NUM_ITER]),
        .in_ready  (ch_ready[NUM_ITER]),
        .in_z      (ch_z[NUM_ITER]),
        .in_zero   (ch_zero[NUM_ITER]),
        .out_valid (post_valid),
        .out_ready (post_ready),
        .out_rad   (post_rad),
        .out_deg   (post_deg)
    );

    // Map to the hue wheel; its registers are the output register of the block.
    mhrgb_color u_color (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (post_valid),
        .in_ready  (post_ready),
        .in_rad    (post_rad),
        .in_deg    (post_deg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_rad   (m_heading_radians),
        .out_deg   (m_heading_degrees),
        .out_red   (m_red_level),
        .out_green (m_green_level),
        .out_blue  (m_blue_level)
    );

endmodule

>>> src/mhrgb_checker.sv
`include "assert_macros.svh"

module mhrgb_checker
    import mhrgb_pkg::*;
(
    input logic   aclk,
    input logic   aresetn,
    input logic   s_ready,
    input logic   m_valid,
    input logic   m_ready,
    input rad_t   m_heading_radians,
    input deg_t   m_heading_degrees,
    input level_t m_red_level,
    input level_t m_green_level,
    input level_t m_blue_level
);

    logic [54:0] m_beat;
    logic        heading_ok;
    logic        dark_ok;

    assign m_beat     = {m_heading_radians, m_heading_degrees,
                         m_red_level, m_green_level, m_blue_level};
    assign heading_ok = (m_heading_degrees <= DEG64_MAX) && (m_heading_radians <= 16'd51471);
    assign dark_ok    = (m_red_level == '0) || (m_green_level == '0) || (m_blue_level == '0);

    `MHRGB_ASSERT_NR(a_reset_empties, aclk, !aresetn |=> !m_valid, "output valid after reset")

    `MHRGB_ASSERT(a_hold_stalled, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_beat), "stalled result changed")

    `MHRGB_ASSERT(a_ready_when_drained, aclk, aresetn, !m_valid |-> s_ready,
        "input stalled with empty output")

    `MHRGB_ASSERT(a_heading_range, aclk, aresetn, m_valid |-> heading_ok,
        "heading out of range")

    `MHRGB_ASSERT(a_one_channel_off, aclk, aresetn, m_valid |-> dark_ok,
        "hue color has no dark channel")

endmodule

bind magnetometer_heading_to_rgb_top mhrgb_checker u_mhrgb_checker (.*);

>>> sim/magnetometer_heading_to_rgb_top_test.sv
// Self-checking bench for the heading-to-color pipeline.
//
// Each sample sent into the block gets its expected heading and color worked out
// here at the moment of acceptance. The expectation is queued. The result monitor
// pops the oldest one for every result beat and compares all five fields.
// Both sides stall at random. One phase holds the result side off long enough to
// back the pipe up into the input. Another phase drains the block completely
// before it resumes.
module magnetometer_heading_to_rgb_top_test;
    import mhrgb_pkg::*;

    localparam int SW           = SAMPLE_WIDTH_DEF;
    localparam int ROT_STEPS    = (CORDIC_ITERATIONS_DEF < 24) ? CORDIC_ITERATIONS_DEF : 24;
    localparam int PIPE_DEPTH   = CORDIC_ITERATIONS_DEF + 4;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;
    localparam int STALL_PCT    = 26;

    // angle constants in units of 2^-28 rad, degree scale is 11520/pi in Q.20
    localparam longint       HALF_TURN_Q28 = 64'sd843314857;
    localparam longint       FULL_TURN_Q28 = 64'sd1686629713;
    localparam bit [63:0]    DEG64_PER_RAD = 64'd3845054675;
    localparam bit [63:0]    DEG64_CEILING = 64'd23039;
    localparam bit [63:0]    HUE_SEGMENT   = 64'd7680;

    typedef logic signed [SW-1:0] sample_t;

    typedef struct {
        sample_t x;
        sample_t y;
        rad_t    rad;
        deg_t    deg;
        level_t  red;
        level_t  green;
        level_t  blue;
    } heading_color_t;

    // atan(2^-i), Q28 radians
    longint arctan_q28 [0:23] = '{
        210828714, 124459457, 65760959, 33381290,
        16755422, 8385879, 4193963, 2097109,
        1048571, 524287, 262144, 131072,
        65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512,
        256, 128, 64, 32
    };

    logic    aclk     = 1'b0;
    logic    aresetn  = 1'b0;
    logic    s_valid  = 1'b0;
    logic    s_ready;
    sample_t s_mag_x  = '0;
    sample_t s_mag_y  = '0;
    logic    m_valid;
    logic    m_ready  = 1'b0;
    rad_t    m_heading_radians;
    deg_t    m_heading_degrees;
    level_t  m_red_level;
    level_t  m_green_level;
    level_t  m_blue_level;

    heading_color_t pending_headings [$];
    int mismatches    = 0;
    int stall_pct     = STALL_PCT;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    magnetometer_heading_to_rgb_top u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mag_x           (s_mag_x),
        .s_mag_y           (s_mag_y),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_heading_radians (m_heading_radians),
        .m_heading_degrees (m_heading_degrees),
        .m_red_level       (m_red_level),
        .m_green_level     (m_green_level),
        .m_blue_level      (m_blue_level)
    );

    always #5 aclk = ~aclk;

    // Compute heading and hue-wheel color for one sample.
    function automatic heading_color_t compute_heading(input sample_t sx, input sample_t sy);
        heading_color_t h;
        longint    x, y, ang, xs, ys;
        bit [63:0] uang, deg, seg, frac, rise, fall;
        int        i;
        x   = sx;
        y   = sy;
        ang = 0;
        // A zero vector keeps a zero heading.
        if (x != 0 || y != 0) begin
            // Turn the left half plane by pi so the rotations converge.
            if (x < 0) begin
                x   = -x;
                y   = -y;
                ang = HALF_TURN_Q28;
            end
            for (i = 0; i < ROT_STEPS; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x   = x + ys;
                    y   = y - xs;
                    ang = ang + arctan_q28[i];
                end else begin
                    x   = x - ys;
                    y   = y + xs;
                    ang = ang - arctan_q28[i];
                end
            end
            // Fold into [0, 2*pi).
            if (ang < 0)
                ang = ang + FULL_TURN_Q28;
            else if (ang >= FULL_TURN_Q28)
                ang = ang - FULL_TURN_Q28;
        end
        uang = ang;
        deg  = (uang * DEG64_PER_RAD) >> 48;
        if (deg > DEG64_CEILING)
            deg = DEG64_CEILING;
        seg  = deg / HUE_SEGMENT;
        frac = deg - seg * HUE_SEGMENT;
        rise = (frac * 255) / HUE_SEGMENT;
        fall = ((HUE_SEGMENT - frac) * 255) / HUE_SEGMENT;
        h.x   = sx;
        h.y   = sy;
        h.rad = rad_t'(uang >> 15);
        h.deg = deg_t'(deg);
        case (seg)
            0: begin
                h.red = level_t'(fall); h.green = level_t'(rise); h.blue = '0;
            end
            1: begin
                h.red = '0; h.green = level_t'(fall); h.blue = level_t'(rise);
            end
            default: begin
                h.red = level_t'(rise); h.green = '0; h.blue = level_t'(fall);
            end
        endcase
        return h;
    endfunction

    // Send one sample beat. Call at a rising edge; returns at the edge that accepts it,
    // with s_valid still high so a back-to-back beat needs no second assignment.
    task automatic send_sample(input sample_t x, input sample_t y);
        int gap;
        gap = 0;
        while (gap < 8 && $urandom_range(99) < stall_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mag_x <= x;
        s_mag_y <= y;
        do @(posedge aclk); while (!s_ready);
        pending_headings.push_back(compute_heading(x, y));
    endtask

    // Drop valid and hold off until every queued heading has come back.
    task automatic drain_headings();
        s_valid <= 1'b0;
        while (pending_headings.size() != 0)
            @(posedge aclk);
    endtask

    // Draw one sample: mostly full range, with small vectors, near-axis
    // vectors and rail values mixed in.
    task automatic draw_sample(output sample_t x, output sample_t y);
        int pick;
        pick = $urandom_range(99);
        if (pick < 60) begin
            x = sample_t'($urandom);
            y = sample_t'($urandom);
        end else if (pick < 75) begin
            x = sample_t'($urandom_range(16) - 8);
            y = sample_t'($urandom_range(16) - 8);
        end else if (pick < 90) begin
            x = sample_t'($urandom);
            y = sample_t'($urandom_range(2) - 1);
            if ($urandom_range(1)) begin
                y = x;
                x = sample_t'($urandom_range(2) - 1);
            end
        end else begin
            x = $urandom_range(1) ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
            y = $urandom_range(1) ? {1'b1, {(SW-1){1'b0}}} : sample_t'($urandom);
        end
    endtask

    task automatic test_directed();
        sample_t xs [$];
        sample_t ys [$];
        int      k;
        // zero vector, axes at both rails, diagonals, unit vectors, the pi turn,
        // just off the fold point, and the 120/240 degree hue boundaries
        xs = '{0, 32767, -32768, 0, 0, 32767, -32768, 32767, -32768, -1, -1, 1, 0,
               0, -1, 1, 32767, -32768, -32768, -16384, -16384, 32767, 1};
        ys = '{0, 0, 0, 32767, -32768, 32767, -32768, -32768, 32767, 0, -1, 0, 1,
               -1, 1, -1, -1, -1, 1, 28378, -28378, 1, 32767};
        for (k = 0; k < xs.size(); k++)
            send_sample(xs[k], ys[k]);
    endtask

    task automatic test_random_samples(input int count, input int pct);
        sample_t x, y;
        int      k;
        stall_pct = pct;
        for (k = 0; k < count; k++) begin
            draw_sample(x, y);
            send_sample(x, y);
        end
        stall_pct = STALL_PCT;
    endtask

    // Hold the result side off while samples keep coming, so the pipe fills
    // and the input stalls.
    task automatic test_backpressure();
        sample_t x, y;
        int      k;
        stall_pct = 0;
        hold_requests++;
        for (k = 0; k < 80; k++) begin
            draw_sample(x, y);
            send_sample(x, y);
        end
        stall_pct = STALL_PCT;
    endtask

    // Empty the block completely, then resume.
    task automatic test_drain_and_resume();
        test_random_samples(20, STALL_PCT);
        drain_headings();
        @(posedge aclk);
        test_random_samples(20, STALL_PCT);
    endtask

    // Result side: random stalls, plus a long hold when one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            m_ready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Check every result beat against the oldest queued heading.
    always @(posedge aclk) begin
        heading_color_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_headings.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: rad %0d deg %0d rgb %0d %0d %0d",
                        m_heading_radians, m_heading_degrees,
                        m_red_level, m_green_level, m_blue_level);
            end else begin
                want = pending_headings.pop_front();
                if (m_heading_radians !== want.rad || m_heading_degrees !== want.deg ||
                    m_red_level !== want.red || m_green_level !== want.green ||
                    m_blue_level !== want.blue) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch x %0d y %0d: rad %0d/%0d deg %0d/%0d ",
                                  "r %0d/%0d g %0d/%0d b %0d/%0d (expected/actual)"},
                            want.x, want.y, want.rad, m_heading_radians,
                            want.deg, m_heading_degrees, want.red, m_red_level,
                            want.green, m_green_level, want.blue, m_blue_level);
                end
            end
        end
    end

    // Watchdog: end the run if it hangs.
    initial begin
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge aclk);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int waited;
        // Hold reset low from the start, then release it on an edge.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_samples(300, STALL_PCT);
        // a long stretch with no stalls on either side
        test_random_samples(150, 0);
        test_backpressure();
        test_drain_and_resume();
        test_random_samples(400, STALL_PCT);

        // Drop valid, wait for the last results, then give stray beats time to show.
        s_valid <= 1'b0;
        waited = 0;
        while (pending_headings.size() != 0 && waited < 10 * HOLD_CYCLES) begin
            @(posedge aclk);
            waited++;
        end
        repeat (PIPE_DEPTH + 10) @(posedge aclk);

        if (mismatches == 0 && pending_headings.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
